>>> rtl/kivc_pkg.sv
// Shared constants, types and state codes for the keystroke interval variance check.
`default_nettype none

package kivc_pkg;

  // Window and field sizes
  localparam int WINDOW_DEPTH   = 16;
  localparam int SLOT_W         = $clog2(WINDOW_DEPTH);
  localparam int FILL_W         = $clog2(WINDOW_DEPTH + 1);
  localparam int INTERVAL_BITS  = 24;
  localparam int STAMP_W        = 32;
  localparam int SUM_W          = INTERVAL_BITS + SLOT_W;
  localparam int SQ_W           = 2 * INTERVAL_BITS + SLOT_W;
  localparam int LIMIT_W        = 24;
  localparam int OUTLIER_FACTOR = 20;
  localparam int OUTLIER_W      = INTERVAL_BITS + 5;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_DEVIATION = 1'b0;
  localparam logic REG_MEAN      = 1'b1;

  // Result stream
  localparam int OUT_W = 8;

  // Serial multiplier sizes and step counts (one multiplier bit per step)
  localparam int MUL_A_W   = 64;
  localparam int MUL_B_W   = 32;
  localparam int STEP_W    = 6;
  localparam logic [STEP_W-1:0] STEPS_SQUARE = STEP_W'(INTERVAL_BITS);
  localparam logic [STEP_W-1:0] STEPS_FILL   = STEP_W'(FILL_W);
  localparam logic [STEP_W-1:0] STEPS_SUM    = STEP_W'(SUM_W);
  localparam logic [STEP_W-1:0] STEPS_DEV    = STEP_W'(LIMIT_W + FILL_W);

  // Request to the serial multiplier
  typedef struct packed {
    logic                 start;
    logic [STEP_W-1:0]    steps;
    logic [MUL_A_W-1:0]   mcand;
    logic [MUL_B_W-1:0]   mplier;
  } mul_req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_VSQ,
    ST_OSQ,
    ST_UPD,
    ST_START,
    ST_NQ,
    ST_SS,
    ST_ND,
    ST_DD,
    ST_NM,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/kivc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kivc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/kivc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module kivc_mul (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire kivc_pkg::mul_req_t        req,
  output logic [kivc_pkg::MUL_A_W-1:0]   prod,
  output logic                           done
);

  logic [kivc_pkg::MUL_A_W-1:0] acc;
  logic [kivc_pkg::MUL_A_W-1:0] mcand;
  logic [kivc_pkg::MUL_B_W-1:0] mplier;
  logic [kivc_pkg::STEP_W-1:0]  count;
  logic                         busy;

  // Control: step counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= req.steps;
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == kivc_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand when the low multiplier bit is set
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc    <= '0;
      mcand  <= req.mcand;
      mplier <= req.mplier;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

>>> rtl/kivc_cfg.sv
// APB register file holding the deviation and mean limits.
`default_nettype none

module kivc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [kivc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [kivc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [kivc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output logic      [kivc_pkg::LIMIT_W-1:0]     deviation_limit,
  output logic      [kivc_pkg::LIMIT_W-1:0]     mean_limit
);

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite && pready;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      deviation_limit <= '0;
      mean_limit      <= '0;
    end else if (wr_en) begin
      case (reg_index)
        kivc_pkg::REG_DEVIATION: deviation_limit <= pwdata[kivc_pkg::LIMIT_W-1:0];
        kivc_pkg::REG_MEAN:      mean_limit      <= pwdata[kivc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_index)
      kivc_pkg::REG_DEVIATION: prdata = kivc_pkg::APB_DATA_W'(deviation_limit);
      kivc_pkg::REG_MEAN:      prdata = kivc_pkg::APB_DATA_W'(mean_limit);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/keystroke_interval_variance_check_top.sv
// A first event skips the arithmetic; other events take a path that depends on whether
// the outlier is dropped, the window is not yet full or the window is full.
// Throughput: one item at a time; the next transfer is taken the cycle after the
// result loads the output register. The shared bit-serial multiplier retires one
// multiplier bit per cycle.
// Reset: synchronous, clears the stamp, window fill, sums, outlier flag and limits.
`default_nettype none

module keystroke_interval_variance_check_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [kivc_pkg::STAMP_W-1:0]     s_tdata,   // [31:0] timestamp
  // Result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [kivc_pkg::OUT_W-1:0]       m_tdata,   // [0] looks_normal, [5:1] window_fill
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [kivc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [kivc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [kivc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);

  localparam int IB = kivc_pkg::INTERVAL_BITS;

  kivc_pkg::state_t state, state_next;

  logic [kivc_pkg::STAMP_W-1:0]     prev_stamp;
  logic [kivc_pkg::FILL_W-1:0]      fill;
  logic [kivc_pkg::SLOT_W-1:0]      oldest;
  logic [kivc_pkg::SUM_W-1:0]       isum;
  logic [kivc_pkg::SQ_W-1:0]        qsum;
  logic                             outlier_used;
  logic [IB-1:0]                    interval;
  logic [2*IB-1:0]                  vsq;
  logic [2*IB-1:0]                  osq;
  logic [kivc_pkg::MUL_A_W-1:0]     spread;
  logic [kivc_pkg::MUL_A_W-1:0]     lim;
  logic                             res_normal;

  logic [kivc_pkg::LIMIT_W-1:0]     deviation_limit;
  logic [kivc_pkg::LIMIT_W-1:0]     mean_limit;

  logic [IB-1:0]                    ram_rdata;
  logic [kivc_pkg::SLOT_W-1:0]      ram_raddr;
  logic                             ram_we;
  logic [kivc_pkg::SLOT_W-1:0]      wr_slot;

  kivc_pkg::mul_req_t               mul_req;
  logic [kivc_pkg::MUL_A_W-1:0]     mul_prod;
  logic                             mul_done;

  logic [kivc_pkg::STAMP_W-1:0]     gap;
  logic [IB-1:0]                    gap_sat;
  logic [kivc_pkg::SLOT_W:0]        newest_sum;
  logic [kivc_pkg::SLOT_W:0]        tail_sum;
  logic [kivc_pkg::SLOT_W-1:0]      newest_slot;
  logic [kivc_pkg::SLOT_W-1:0]      tail_slot;
  logic                             full;
  logic [kivc_pkg::OUTLIER_W-1:0]   outlier_bound;
  logic                             outlier_hit;
  logic                             accept;
  logic                             out_free;

  // Configuration registers
  kivc_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .deviation_limit (deviation_limit),
    .mean_limit      (mean_limit)
  );

  // Interval window storage
  kivc_ram #(
    .WIDTH (IB),
    .DEPTH (kivc_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot),
    .wdata (interval),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared serial multiplier
  kivc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .prod (mul_prod),
    .done (mul_done)
  );

  // Interval since the previous stamp, saturated
  assign gap     = s_tdata - prev_stamp;
  assign gap_sat = (|gap[kivc_pkg::STAMP_W-1:IB]) ? {IB{1'b1}} : gap[IB-1:0];

  // Slot arithmetic around the ring
  assign newest_sum  = {1'b0, oldest} + fill - 1'b1;
  assign tail_sum    = {1'b0, oldest} + fill;
  assign newest_slot = (newest_sum >= (kivc_pkg::SLOT_W+1)'(kivc_pkg::WINDOW_DEPTH))
                     ? kivc_pkg::SLOT_W'(newest_sum - kivc_pkg::WINDOW_DEPTH)
                     : newest_sum[kivc_pkg::SLOT_W-1:0];
  assign tail_slot   = (tail_sum >= (kivc_pkg::SLOT_W+1)'(kivc_pkg::WINDOW_DEPTH))
                     ? kivc_pkg::SLOT_W'(tail_sum - kivc_pkg::WINDOW_DEPTH)
                     : tail_sum[kivc_pkg::SLOT_W-1:0];
  assign full        = (fill == kivc_pkg::FILL_W'(kivc_pkg::WINDOW_DEPTH));
  assign wr_slot     = full ? oldest : tail_slot;

  // Outlier test against the newest held interval
  assign outlier_bound = kivc_pkg::OUTLIER_W'(ram_rdata)
                       * kivc_pkg::OUTLIER_W'(kivc_pkg::OUTLIER_FACTOR);
  assign outlier_hit   = !outlier_used && (fill != '0)
                       && (kivc_pkg::OUTLIER_W'(interval) > outlier_bound);

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kivc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (prev_stamp == '0) ? kivc_pkg::ST_DONE : kivc_pkg::ST_CHECK;
        end
      end
      kivc_pkg::ST_CHECK: begin
        state_next = outlier_hit ? kivc_pkg::ST_START : kivc_pkg::ST_VSQ;
      end
      kivc_pkg::ST_VSQ: begin
        if (mul_done) begin
          state_next = full ? kivc_pkg::ST_OSQ : kivc_pkg::ST_UPD;
        end
      end
      kivc_pkg::ST_OSQ:   if (mul_done) state_next = kivc_pkg::ST_UPD;
      kivc_pkg::ST_UPD:   state_next = kivc_pkg::ST_START;
      kivc_pkg::ST_START: state_next = kivc_pkg::ST_NQ;
      kivc_pkg::ST_NQ:    if (mul_done) state_next = kivc_pkg::ST_SS;
      kivc_pkg::ST_SS:    if (mul_done) state_next = kivc_pkg::ST_ND;
      kivc_pkg::ST_ND:    if (mul_done) state_next = kivc_pkg::ST_DD;
      kivc_pkg::ST_DD:    if (mul_done) state_next = kivc_pkg::ST_NM;
      kivc_pkg::ST_NM:    if (mul_done) state_next = kivc_pkg::ST_DONE;
      kivc_pkg::ST_DONE:  if (out_free) state_next = kivc_pkg::ST_IDLE;
      default:            state_next = kivc_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake, RAM port and multiplier requests
  always_comb begin
    s_tready  = (state == kivc_pkg::ST_IDLE);
    ram_raddr = (state == kivc_pkg::ST_IDLE) ? newest_slot : oldest;
    ram_we    = (state == kivc_pkg::ST_UPD);
    mul_req   = '0;
    case (state)
      kivc_pkg::ST_CHECK: begin
        if (!outlier_hit) begin
          mul_req.start  = 1'b1;
          mul_req.steps  = kivc_pkg::STEPS_SQUARE;
          mul_req.mcand  = kivc_pkg::MUL_A_W'(interval);
          mul_req.mplier = kivc_pkg::MUL_B_W'(interval);
        end
      end
      kivc_pkg::ST_VSQ: begin
        if (mul_done && full) begin
          mul_req.start  = 1'b1;
          mul_req.steps  = kivc_pkg::STEPS_SQUARE;
          mul_req.mcand  = kivc_pkg::MUL_A_W'(ram_rdata);
          mul_req.mplier = kivc_pkg::MUL_B_W'(ram_rdata);
        end
      end
      kivc_pkg::ST_START: begin
        mul_req.start  = 1'b1;
        mul_req.steps  = kivc_pkg::STEPS_FILL;
        mul_req.mcand  = kivc_pkg::MUL_A_W'(qsum);
        mul_req.mplier = kivc_pkg::MUL_B_W'(fill);
      end
      kivc_pkg::ST_NQ: begin
        if (mul_done) begin
          mul_req.start  = 1'b1;
          mul_req.steps  = kivc_pkg::STEPS_SUM;
          mul_req.mcand  = kivc_pkg::MUL_A_W'(isum);
          mul_req.mplier = kivc_pkg::MUL_B_W'(isum);
        end
      end
      kivc_pkg::ST_SS: begin
        if (mul_done) begin
          mul_req.start  = 1'b1;
          mul_req.steps  = kivc_pkg::STEPS_FILL;
          mul_req.mcand  = kivc_pkg::MUL_A_W'(deviation_limit);
          mul_req.mplier = kivc_pkg::MUL_B_W'(fill);
        end
      end
      kivc_pkg::ST_ND: begin
        if (mul_done) begin
          mul_req.start  = 1'b1;
          mul_req.steps  = kivc_pkg::STEPS_DEV;
          mul_req.mcand  = mul_prod;
          mul_req.mplier = mul_prod[kivc_pkg::MUL_B_W-1:0];
        end
      end
      kivc_pkg::ST_DD: begin
        if (mul_done) begin
          mul_req.start  = 1'b1;
          mul_req.steps  = kivc_pkg::STEPS_FILL;
          mul_req.mcand  = kivc_pkg::MUL_A_W'(mean_limit);
          mul_req.mplier = kivc_pkg::MUL_B_W'(fill);
        end
      end
      default: ;
    endcase
  end

  // State register and window control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kivc_pkg::ST_IDLE;
      prev_stamp   <= '0;
      fill         <= '0;
      oldest       <= '0;
      isum         <= '0;
      qsum         <= '0;
      outlier_used <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        prev_stamp <= s_tdata;
      end
      if (state == kivc_pkg::ST_CHECK && outlier_hit) begin
        outlier_used <= 1'b1;
      end
      // Commit the new interval: drop the oldest when the window is full
      if (state == kivc_pkg::ST_UPD) begin
        isum <= isum + kivc_pkg::SUM_W'(interval)
              - (full ? kivc_pkg::SUM_W'(ram_rdata) : '0);
        qsum <= qsum + kivc_pkg::SQ_W'(vsq) - kivc_pkg::SQ_W'(osq);
        if (full) begin
          oldest <= (oldest == kivc_pkg::SLOT_W'(kivc_pkg::WINDOW_DEPTH - 1))
                  ? '0 : oldest + 1'b1;
        end else begin
          fill <= fill + 1'b1;
        end
      end
      // Hold the result until the output register frees up
      if (state == kivc_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers: interval, partial products and verdict
  always_ff @(posedge clk) begin
    if (accept) begin
      interval <= gap_sat;
      if (prev_stamp == '0) begin
        res_normal <= 1'b1;
      end
    end
    if (state == kivc_pkg::ST_VSQ && mul_done) begin
      vsq <= mul_prod[2*IB-1:0];
      osq <= '0;
    end
    if (state == kivc_pkg::ST_OSQ && mul_done) begin
      osq <= mul_prod[2*IB-1:0];
    end
    if (state == kivc_pkg::ST_NQ && mul_done) begin
      spread <= mul_prod;
    end
    if (state == kivc_pkg::ST_SS && mul_done) begin
      spread <= spread - mul_prod;
    end
    if (state == kivc_pkg::ST_DD && mul_done) begin
      lim <= mul_prod;
    end
    if (state == kivc_pkg::ST_NM && mul_done) begin
      res_normal <= (fill < kivc_pkg::FILL_W'(2)) || (qsum == '0) || (spread > lim)
                  || (kivc_pkg::MUL_A_W'(isum) > mul_prod);
    end
    if (state == kivc_pkg::ST_DONE && out_free) begin
      m_tdata <= kivc_pkg::OUT_W'({fill, res_normal});
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_keystroke_interval_variance_check_top.sv
// Testbench for the keystroke interval variance check: stream stimulus, prediction, checks.
`timescale 1ns / 100ps

module tb_keystroke_interval_variance_check_top;
  import kivc_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 150;
  localparam longint unsigned INTERVAL_MAX = (64'd1 << INTERVAL_BITS) - 64'd1;
  localparam longint unsigned LIMIT_MASK = (64'd1 << LIMIT_W) - 64'd1;

  typedef struct packed {
    logic                looks_normal;
    logic [FILL_W-1:0]   window_fill;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [STAMP_W-1:0]    s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state: stamp, interval window, running sums and limits
  logic [STAMP_W-1:0]       last_stamp;
  logic [INTERVAL_BITS-1:0] window_held [WINDOW_DEPTH];
  int                       fill_held;
  int                       oldest_idx;
  longint unsigned          interval_total;
  longint unsigned          square_total;
  bit                       outlier_spent;
  longint unsigned          dev_limit;
  longint unsigned          mean_limit;

  verdict_t expected_verdicts[$];

  // Stimulus shaping and bookkeeping
  logic [STAMP_W-1:0] clock_ms;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_off_cycles = 0;
  int error_count = 0;
  int stamps_sent = 0;
  int verdicts_seen = 0;
  int normal_seen = 0;
  int outliers_dropped = 0;
  int limit_settings = 0;
  int cycle_count = 0;

  keystroke_interval_variance_check_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [31:0] timestamp
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [0] looks_normal, [5:1] window_fill
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
               expected_verdicts.size());
      $display("tb_keystroke_interval_variance_check_top: done, errors");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Advance the predictor by one accepted stamp and queue the verdict it gives
  task automatic predict_verdict(input logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] gap;
    longint unsigned iv, newest, old, n, spread;
    bit store;
    verdict_t v;
    if (last_stamp == '0) begin
      // first event: keep the stamp, leave the window alone
      last_stamp = stamp;
      v.looks_normal = 1'b1;
      v.window_fill = FILL_W'(fill_held);
    end else begin
      gap = stamp - last_stamp;
      iv = (gap > INTERVAL_MAX) ? INTERVAL_MAX : longint'(gap);
      store = 1'b1;
      // drop one outlier interval, once per reset
      if (!outlier_spent && fill_held != 0) begin
        newest = window_held[(oldest_idx + fill_held - 1) % WINDOW_DEPTH];
        if (iv > newest * OUTLIER_FACTOR) begin
          outlier_spent = 1'b1;
          store = 1'b0;
          outliers_dropped++;
        end
      end
      if (store) begin
        if (fill_held < WINDOW_DEPTH) begin
          window_held[(oldest_idx + fill_held) % WINDOW_DEPTH] = iv[INTERVAL_BITS-1:0];
          fill_held++;
        end else begin
          // full window: retire the oldest interval from the sums
          old = window_held[oldest_idx];
          interval_total -= old;
          square_total -= old * old;
          window_held[oldest_idx] = iv[INTERVAL_BITS-1:0];
          oldest_idx = (oldest_idx + 1) % WINDOW_DEPTH;
        end
        interval_total += iv;
        square_total += iv * iv;
      end
      last_stamp = stamp;
      n = fill_held;
      v.window_fill = FILL_W'(fill_held);
      if (n < 2 || square_total == 0) begin
        v.looks_normal = 1'b1;
      end else begin
        spread = n * square_total - interval_total * interval_total;
        v.looks_normal = (spread > dev_limit * dev_limit * n * n) ||
                         (interval_total > mean_limit * n);
      end
    end
    expected_verdicts = {expected_verdicts, v};
  endtask

  // Offer one stamp, with an optional idle burst first; tvalid stays high afterwards
  task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
    int pause;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      pause = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= stamp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_verdict(stamp);
    stamps_sent++;
  endtask

  // Drop tvalid and hold until every queued verdict has come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic which, input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (which == REG_DEVIATION) dev_limit = value & LIMIT_MASK;
    else mean_limit = value & LIMIT_MASK;
  endtask

  // Change both limits with the block idle
  task automatic set_limits(input logic [APB_DATA_W-1:0] dev,
                            input logic [APB_DATA_W-1:0] mean);
    wait_drain();
    write_limit(REG_DEVIATION, dev);
    write_limit(REG_MEAN, mean);
    limit_settings++;
  endtask

  // Send keystrokes spaced base +/- jitter apart (jitter at most base)
  task automatic type_burst(input int count, input int base, input int jitter);
    for (int i = 0; i < count; i++) begin
      clock_ms = clock_ms + base - jitter + $urandom_range(0, 2 * jitter);
      send_stamp(clock_ms);
    end
  endtask

  // Hand out ready in random stall bursts; honor a requested long hold-off
  initial begin : sink_side
    int stall;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        m_tready <= 1'b1;
      end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        stall = $urandom_range(1, 8);
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest pending verdict
  always @(posedge clk) begin : check_results
    verdict_t want;
    verdict_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.looks_normal = m_tdata[0];
      got.window_fill = m_tdata[FILL_W:1];
      verdicts_seen++;
      if (got.looks_normal) normal_seen++;
      if (expected_verdicts.size() == 0) begin
        flag_error($sformatf("result %0d with nothing pending: looks_normal %0b fill %0d",
                             verdicts_seen, got.looks_normal, got.window_fill));
      end else begin
        want = expected_verdicts.pop_front();
        if (got.looks_normal !== want.looks_normal)
          flag_error($sformatf("result %0d looks_normal: expected %0b, got %0b",
                               verdicts_seen, want.looks_normal, got.looks_normal));
        if (got.window_fill !== want.window_fill)
          flag_error($sformatf("result %0d window_fill: expected %0d, got %0d",
                               verdicts_seen, want.window_fill, got.window_fill));
      end
    end
  end

  // First events, zero stamps, zero squares, outlier, wrap, saturation, full window
  task automatic test_directed_cases();
    logic [STAMP_W-1:0] opening [11] = '{
      32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFF0, 32'hFFFF_FFF0, 32'hFFFF_FFF0,
      32'hFFFF_FFF1, 32'h0000_0010, 32'h8000_0010, 32'h0000_0000, 32'h1234_5678,
      32'h1234_56DC};
    src_idle_pct = 20;
    sink_stall_pct = 20;
    foreach (opening[i]) send_stamp(opening[i]);
    clock_ms = opening[10];
    // top limits, upper pwdata bits set and masked off
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    type_burst(12, 100, 2);
  endtask

  // Realistic typing at varied tempo and steadiness against moderate limits
  task automatic test_typing_rhythm();
    int base;
    for (int seg = 0; seg < 6; seg++) begin
      set_limits($urandom_range(0, 60), $urandom_range(60, 320));
      src_idle_pct = (seg % 3) * 25;
      sink_stall_pct = ((seg + 1) % 3) * 25;
      base = $urandom_range(40, 300);
      type_burst(30, base, $urandom_range(0, base / 2));
    end
  endtask

  // Stamps over the whole 32-bit range: wraps, zero stamps, saturating gaps
  task automatic test_wide_stamps();
    logic [STAMP_W-1:0] stamp;
    src_idle_pct = 30;
    sink_stall_pct = 30;
    for (int half = 0; half < 2; half++) begin
      if (half == 0) set_limits($urandom(), $urandom());
      else set_limits($urandom_range(0, 4095), $urandom_range(0, 65535));
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(0, 7))
          0, 1, 2: stamp = $urandom();
          3:       stamp = '0;
          4:       stamp = '1;
          5:       stamp = clock_ms + $urandom_range(0, 32'h01FF_FFFF);
          default: stamp = clock_ms + $urandom_range(0, 500);
        endcase
        clock_ms = stamp;
        send_stamp(stamp);
      end
    end
  endtask

  // Long receiver hold-off while stamps keep coming, then a full drain
  task automatic test_backpressure();
    set_limits($urandom_range(5, 40), $urandom_range(80, 200));
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_off_cycles = 300;
    type_burst(20, 120, 30);
    wait_drain();
    sink_stall_pct = 25;
    hold_off_cycles = 400;
    type_burst(20, 90, 10);
    wait_drain();
  endtask

  // Zero, top and middle limit combinations
  task automatic test_limit_sweep();
    logic [APB_DATA_W-1:0] dev_set [5] = '{32'd0, 32'd0, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'd0};
    logic [APB_DATA_W-1:0] mean_set [5] = '{32'd0, 32'h00FF_FFFF, 32'd0, 32'h00FF_FFFF, 32'd0};
    int base;
    dev_set[4] = $urandom_range(1, 50);
    mean_set[4] = $urandom_range(50, 250);
    src_idle_pct = 15;
    sink_stall_pct = 15;
    foreach (dev_set[k]) begin
      set_limits(dev_set[k], mean_set[k]);
      base = $urandom_range(30, 250);
      type_burst(15, base, 0);
      type_burst(15, base, $urandom_range(1, base / 2));
    end
  endtask

  // Closing stretch with both sides always ready
  task automatic test_steady_finish();
    set_limits($urandom_range(0, 30), $urandom_range(100, 180));
    src_idle_pct = 0;
    sink_stall_pct = 0;
    type_burst(30, 140, 5);
    type_burst(30, 140, 70);
  endtask

  initial begin
    last_stamp = '0;
    fill_held = 0;
    oldest_idx = 0;
    interval_total = 0;
    square_total = 0;
    outlier_spent = 1'b0;
    dev_limit = 0;
    mean_limit = 0;
    clock_ms = 32'h0000_1000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);
    test_directed_cases();
    test_typing_rhythm();
    test_wide_stamps();
    test_backpressure();
    test_limit_sweep();
    test_steady_finish();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d stamps and %0d verdicts (%0d normal, %0d flagged), %0d outlier drop",
             stamps_sent, verdicts_seen, normal_seen, verdicts_seen - normal_seen,
             outliers_dropped);
    $display("over %0d limit settings in %0d cycles, %0d errors", limit_settings,
             cycle_count, error_count);
    if (error_count == 0) begin
      $display("tb_keystroke_interval_variance_check_top: done, clean");
    end else begin
      $display("tb_keystroke_interval_variance_check_top: done, errors");
    end
    $finish;
  end

endmodule
